/* hw/rtl/two_class_weighted_queue_arbiter_unit_macros.svh */
// Assertion macros shared by the arbiter RTL.
// Every macro expects clk and rst_n in scope; checks are off while in reset.
`ifndef TWO_CLASS_WEIGHTED_QUEUE_ARBITER_UNIT_MACROS_SVH
`define TWO_CLASS_WEIGHTED_QUEUE_ARBITER_UNIT_MACROS_SVH

// Same-cycle implication.
`define TCWQA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define TCWQA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tcwqa_pkg.sv */
// Package for the two-class queue arbiter: payload types, codes and sizes.
// Used by two_class_weighted_queue_arbiter_unit; depends on nothing.
`timescale 1ns / 1ps

package tcwqa_pkg;

  // Queue depth must stay a power of two: the slot pointers wrap by truncation.
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ID_WIDTH    = 16;
  localparam int RUN_W       = 4;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [RUN_W-1:0] BURST_LIMIT_RESET = 4'd3;
  localparam logic             REG_BURST_LIMIT   = 1'b0;

  localparam logic [1:0] OP_ENQ_NORMAL   = 2'd0;
  localparam logic [1:0] OP_ENQ_PRIORITY = 2'd1;
  localparam logic [1:0] OP_SERVE        = 2'd2;

  localparam logic [2:0] ST_ENQUEUED   = 3'd0;
  localparam logic [2:0] ST_DROPPED    = 3'd1;
  localparam logic [2:0] ST_SERVED_PRI = 3'd2;
  localparam logic [2:0] ST_SERVED_NRM = 3'd3;
  localparam logic [2:0] ST_WAIT       = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] client_id;
  } tcwqa_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] served_id;
  } tcwqa_out_t;

  // Only the high bit of the operation selects serving, so the unused
  // code decodes as a serve as well.
  function automatic logic is_serve(input logic [1:0] op);
    logic [1:0] masked;
    masked = op & OP_SERVE;
    return masked == OP_SERVE;
  endfunction

endpackage

/* hw/rtl/two_class_weighted_queue_arbiter_unit.sv */
// A request is taken into the input register, and its result into the result
// register, where out_valid rises; out_ready low holds the result and a full input.
// Throughput: one request per cycle unless out_ready stalls; the single pass over
// queue heads, counts and the run counter between the two registers sets it.
// Reset (synchronous, active low) empties both queues, clears the run counter
// and loads burst_limit with 3; queue storage is not cleared and needs no pass.
// File depends on tcwqa_pkg and two_class_weighted_queue_arbiter_unit_macros.svh.
`timescale 1ns / 1ps

`include "two_class_weighted_queue_arbiter_unit_macros.svh"

module two_class_weighted_queue_arbiter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tcwqa_pkg::tcwqa_in_t                in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tcwqa_pkg::tcwqa_out_t               out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tcwqa_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [tcwqa_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [tcwqa_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);
  import tcwqa_pkg::*;

  // Input stage.
  logic       s1_valid_r;
  tcwqa_in_t  s1_data_r;

  // Result stage.
  logic       out_valid_r;
  tcwqa_out_t out_data_r;

  // Arbiter state.
  logic [ID_WIDTH-1:0] pri_store [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] nrm_store [QUEUE_DEPTH];
  logic [IDX_W-1:0]    pri_head_r, pri_head_nxt;
  logic [IDX_W-1:0]    nrm_head_r, nrm_head_nxt;
  logic [CNT_W-1:0]    pri_cnt_r, pri_cnt_nxt;
  logic [CNT_W-1:0]    nrm_cnt_r, nrm_cnt_nxt;
  logic [RUN_W-1:0]    run_r, run_nxt;
  logic [RUN_W-1:0]    burst_limit_r;

  logic        s2_take;
  logic        proc;
  logic        pri_avail;
  logic        nrm_empty;
  logic        under;
  logic        pri_we;
  logic        nrm_we;
  logic [IDX_W-1:0] pri_tail;
  logic [IDX_W-1:0] nrm_tail;
  tcwqa_out_t  res;
  logic        cfg_wr;

  assign s2_take  = !out_valid_r || out_ready;
  assign proc     = s1_valid_r && s2_take;
  assign in_ready = !s1_valid_r || s2_take;

  assign pri_avail = pri_cnt_r != '0;
  assign nrm_empty = nrm_cnt_r == '0;
  assign under     = run_r < burst_limit_r;
  assign pri_tail  = pri_head_r + pri_cnt_r[IDX_W-1:0];
  assign nrm_tail  = nrm_head_r + nrm_cnt_r[IDX_W-1:0];

  always_comb begin
    pri_head_nxt  = pri_head_r;
    nrm_head_nxt  = nrm_head_r;
    pri_cnt_nxt   = pri_cnt_r;
    nrm_cnt_nxt   = nrm_cnt_r;
    run_nxt       = run_r;
    pri_we        = 1'b0;
    nrm_we        = 1'b0;
    res.status    = ST_WAIT;
    res.served_id = '0;
    if (is_serve(s1_data_r.operation)) begin
      if (pri_avail && (under || nrm_empty)) begin
        res.status    = ST_SERVED_PRI;
        res.served_id = 16'(pri_store[pri_head_r]);
        pri_head_nxt  = pri_head_r + 1'b1;
        pri_cnt_nxt   = pri_cnt_r - 1'b1;
        // The run saturates at the limit and keeps its value if the limit drops.
        if (under) begin
          run_nxt = run_r + 1'b1;
        end
      end else if (!nrm_empty) begin
        res.status    = ST_SERVED_NRM;
        res.served_id = 16'(nrm_store[nrm_head_r]);
        nrm_head_nxt  = nrm_head_r + 1'b1;
        nrm_cnt_nxt   = nrm_cnt_r - 1'b1;
        run_nxt       = '0;
      end
    end else if (s1_data_r.operation == OP_ENQ_PRIORITY) begin
      if (pri_cnt_r == CNT_W'(QUEUE_DEPTH)) begin
        res.status = ST_DROPPED;
      end else begin
        res.status  = ST_ENQUEUED;
        pri_we      = proc;
        pri_cnt_nxt = pri_cnt_r + 1'b1;
      end
    end else begin
      if (nrm_cnt_r == CNT_W'(QUEUE_DEPTH)) begin
        res.status = ST_DROPPED;
      end else begin
        res.status  = ST_ENQUEUED;
        nrm_we      = proc;
        nrm_cnt_nxt = nrm_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pri_head_r  <= '0;
      nrm_head_r  <= '0;
      pri_cnt_r   <= '0;
      nrm_cnt_r   <= '0;
      run_r       <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_take) begin
        out_valid_r <= s1_valid_r;
      end
      if (proc) begin
        pri_head_r <= pri_head_nxt;
        nrm_head_r <= nrm_head_nxt;
        pri_cnt_r  <= pri_cnt_nxt;
        nrm_cnt_r  <= nrm_cnt_nxt;
        run_r      <= run_nxt;
      end
    end
  end

  // Payload registers and queue storage carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (proc) begin
      out_data_r <= res;
    end
    if (pri_we) begin
      pri_store[pri_tail] <= s1_data_r.client_id[ID_WIDTH-1:0];
    end
    if (nrm_we) begin
      nrm_store[nrm_tail] <= s1_data_r.client_id[ID_WIDTH-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_limit_r <= BURST_LIMIT_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_BURST_LIMIT) begin
      burst_limit_r <= cfg_pwdata[RUN_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_BURST_LIMIT) begin
      cfg_prdata = CFG_DATA_W'(burst_limit_r);
    end
  end

  `TCWQA_ASSERT_NOW(a_pri_cnt_bound, 1'b1, pri_cnt_r <= CNT_W'(QUEUE_DEPTH), "priority count overflow")
  `TCWQA_ASSERT_NOW(a_nrm_cnt_bound, 1'b1, nrm_cnt_r <= CNT_W'(QUEUE_DEPTH), "normal count overflow")
  `TCWQA_ASSERT_NOW(a_wait_empty, proc && res.status == ST_WAIT, !pri_avail && nrm_empty, "wait with a queue holding clients")
  `TCWQA_ASSERT_NEXT(a_run_clear, proc && res.status == ST_SERVED_NRM, run_r == '0, "run not cleared after normal serve")
  `TCWQA_ASSERT_NOW(a_ready_free, !out_valid_r, in_ready, "input stalled with empty result stage")

endmodule
